[src/frsl_pkg.sv]
package frsl_pkg;

  localparam int unsigned NOW_W    = 32;
  localparam int unsigned RATE_W   = 8;
  localparam int unsigned MISSED_W = 32;
  localparam int unsigned NOM_W    = 12;
  localparam int unsigned SCALE_W  = 17;

  localparam int unsigned MAX_WINDOW_FRAMES_DEF = 40000;

  // nominal rates in hundredths of a frame per second
  localparam int unsigned NOM_30    = 2997;
  localparam int unsigned NOM_1     = 100;
  localparam int unsigned NOM_OTHER = 2500;

  // ms-to-hundredths scale (100 * 1000)
  localparam int unsigned MS_SCALE = 100000;

  localparam logic [RATE_W-1:0] RATE_CODE_30  = RATE_W'(30);
  localparam logic [RATE_W-1:0] RATE_CODE_1   = RATE_W'(1);
  localparam logic [RATE_W-1:0] RATE_RESET    = RATE_CODE_30;

  function automatic logic [NOM_W-1:0] nominal_of(input logic [RATE_W-1:0] rate);
    logic [NOM_W-1:0] nom;
    case (rate)
      RATE_CODE_30: nom = NOM_W'(NOM_30);
      RATE_CODE_1:  nom = NOM_W'(NOM_1);
      default:      nom = NOM_W'(NOM_OTHER);
    endcase
    return nom;
  endfunction

endpackage

[src/frsl_ifs.sv]
interface frsl_in_if;
  logic                           valid;
  logic                           ready;
  logic [frsl_pkg::NOW_W-1:0]     now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

interface frsl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           skip;
  logic [frsl_pkg::MISSED_W-1:0]  frames_missed;
  modport source (output valid, output skip, output frames_missed, input ready);
  modport sink   (input valid, input skip, input frames_missed, output ready);
endinterface

interface frsl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [frsl_pkg::RATE_W-1:0]    frame_rate;
  modport source (output valid, output frame_rate, input ready);
  modport sink   (input valid, input frame_rate, output ready);
endinterface

[src/frame_rate_skip_limiter_top.sv]
// Frame rate skip limiter.
// in_if  : one transfer per arriving frame, payload now_ms (ms timestamp, wraps
//          at 32 bits).
// out_if : one transfer per input frame, in order: skip (1 = drop the frame)
//          and frames_missed (frames dropped in the current window).
// cfg_if : frame_rate register write; always ready. Write only while idle.
//          30 selects 29.97 fps, 1 selects 1 fps, anything else 25 fps.
// Pipeline: a frame taken at in_if goes into the input register, then through
//          the decision logic into the result register that drives out_if.
// Throughput: one frame per cycle while out_if takes results. The window state
//          (start time, frame count, missed count, last rate) is updated at the
//          same edge the result is registered, so the next frame sees it.
// Reset (rst_n low, synchronous): both stages empty, window state cleared,
//          frame_rate back to 30.
// Receiver stall: the result register holds; the input register still takes
//          one more frame, then in_if.ready drops until out_if drains.
module frame_rate_skip_limiter_top #(
  parameter int unsigned MAX_WINDOW_FRAMES = frsl_pkg::MAX_WINDOW_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  frsl_cfg_if.sink    cfg_if,
  frsl_in_if.sink     in_if,
  frsl_out_if.source  out_if
);

  localparam int unsigned NOW_W    = frsl_pkg::NOW_W;
  localparam int unsigned RATE_W   = frsl_pkg::RATE_W;
  localparam int unsigned MISSED_W = frsl_pkg::MISSED_W;
  localparam int unsigned NOM_W    = frsl_pkg::NOM_W;

  // window frame count never exceeds MAX_WINDOW_FRAMES + 1
  localparam int unsigned WF_W = $clog2(MAX_WINDOW_FRAMES + 2);

  // window time limits, ms, per nominal rate
  localparam longint LIM_30 =
    (longint'(MAX_WINDOW_FRAMES) * longint'(frsl_pkg::MS_SCALE)) / frsl_pkg::NOM_30;
  localparam longint LIM_1 =
    (longint'(MAX_WINDOW_FRAMES) * longint'(frsl_pkg::MS_SCALE)) / frsl_pkg::NOM_1;
  localparam longint LIM_OTHER =
    (longint'(MAX_WINDOW_FRAMES) * longint'(frsl_pkg::MS_SCALE)) / frsl_pkg::NOM_OTHER;

  // elapsed time that survives the limit check fits the largest limit
  localparam int unsigned EL_W   = $clog2(LIM_1 + 1);
  localparam int unsigned PROD_W = NOM_W + EL_W;
  localparam int unsigned RHS_W  = WF_W + frsl_pkg::SCALE_W;
  localparam int unsigned CMP_W  = (PROD_W > RHS_W) ? PROD_W : RHS_W;

  localparam logic [NOW_W-1:0] LIM_30_V    = LIM_30[NOW_W-1:0];
  localparam logic [NOW_W-1:0] LIM_1_V     = LIM_1[NOW_W-1:0];
  localparam logic [NOW_W-1:0] LIM_OTHER_V = LIM_OTHER[NOW_W-1:0];
  localparam logic [WF_W-1:0]  MAX_WF_V    = WF_W'(MAX_WINDOW_FRAMES);
  localparam logic [RHS_W-1:0] SCALE_V     = RHS_W'(frsl_pkg::MS_SCALE);

  // config register
  logic [RATE_W-1:0]   frame_rate_r;
  logic                cfg_fire;

  // input stage
  logic                s1_valid_r;
  logic [NOW_W-1:0]    now_r;

  // window state
  logic [NOW_W-1:0]    win_start_r, win_start_nxt;
  logic [WF_W-1:0]     win_frames_r, win_frames_nxt;
  logic [MISSED_W-1:0] missed_r, missed_nxt;
  logic [RATE_W-1:0]   last_rate_r, last_rate_nxt;

  // result stage
  logic                out_valid_r;
  logic                out_skip_r;
  logic [MISSED_W-1:0] out_missed_r;

  logic                out_free;
  logic                s1_adv;
  logic                in_fire;

  // decision path
  logic                restart;
  logic [NOW_W-1:0]    start1;
  logic [WF_W-1:0]     frames1, frames2, frames3;
  logic [MISSED_W-1:0] missed1;
  logic [NOW_W-1:0]    elapsed_raw, elapsed;
  logic [NOW_W-1:0]    limit;
  logic                over;
  logic [EL_W-1:0]     el_n;
  logic [NOM_W-1:0]    nominal;
  logic [PROD_W-1:0]   prod;
  logic [RHS_W-1:0]    rhs;
  logic                skip;

  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid;

  assign out_free     = !out_valid_r || out_if.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_if.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_if.valid && in_if.ready;

  assign nominal = frsl_pkg::nominal_of(frame_rate_r);

  always_comb begin
    case (frame_rate_r)
      frsl_pkg::RATE_CODE_30: limit = LIM_30_V;
      frsl_pkg::RATE_CODE_1:  limit = LIM_1_V;
      default:                limit = LIM_OTHER_V;
    endcase
  end

  always_comb begin
    // window (re)open on a zero start time (as after reset) or a rate change
    restart = (win_start_r == '0) || (last_rate_r != frame_rate_r);
    start1  = restart ? now_r : win_start_r;
    frames1 = restart ? '0 : win_frames_r;
    missed1 = restart ? '0 : missed_r;
    last_rate_nxt = restart ? frame_rate_r : last_rate_r;

    frames2     = frames1 + WF_W'(1);
    elapsed_raw = now_r - start1;
    elapsed     = (elapsed_raw == '0) ? NOW_W'(1) : elapsed_raw;

    // window full or run past its time limit: open a fresh one, frame not counted
    over = (frames2 > MAX_WF_V) || (elapsed > limit);
    if (over) begin
      frames3       = '0;
      win_start_nxt = now_r;
      missed_nxt    = '0;
      el_n          = EL_W'(1);
    end else begin
      frames3       = frames2;
      win_start_nxt = start1;
      missed_nxt    = missed1;
      el_n          = elapsed[EL_W-1:0];
    end

    // skip when frames - 1 > floor(nominal * el / scale),
    // i.e. nominal * el < (frames - 1) * scale
    prod = {{EL_W{1'b0}}, nominal} * {{NOM_W{1'b0}}, el_n};
    rhs  = RHS_W'(frames3 - WF_W'(1)) * SCALE_V;
    skip = (frames3 != '0) && (CMP_W'(prod) < CMP_W'(rhs));

    win_frames_nxt = skip ? (frames3 - WF_W'(1)) : frames3;
    if (skip) begin
      missed_nxt = missed_nxt + MISSED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rate_r <= frsl_pkg::RATE_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      win_start_r  <= '0;
      win_frames_r <= '0;
      missed_r     <= '0;
      last_rate_r  <= '0;
    end else begin
      if (cfg_fire) begin
        frame_rate_r <= cfg_if.frame_rate;
      end
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        win_start_r  <= win_start_nxt;
        win_frames_r <= win_frames_nxt;
        missed_r     <= missed_nxt;
        last_rate_r  <= last_rate_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r <= in_if.now_ms;
    end
    if (s1_adv) begin
      out_skip_r   <= skip;
      out_missed_r <= missed_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.skip          = out_skip_r;
  assign out_if.frames_missed = out_missed_r;

  // stored frame count stays within the window size
  a_frames_bound: assert property (@(posedge clk) disable iff (!rst_n)
    win_frames_r <= MAX_WF_V)
    else $error("window frame count above limit");

  // a waiting frame in the input stage is not lost or overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(now_r)))
    else $error("input stage lost a frame under stall");

  // result stage keeps its item until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> out_valid_r)
    else $error("result dropped under stall");

  // after a processed frame the window tracks the current rate setting
  a_rate_track: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !cfg_fire) |=> (last_rate_r == frame_rate_r))
    else $error("window rate not updated");

  // a frame that opens a fresh window is never skipped
  a_no_skip_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && over) |=> !out_skip_r)
    else $error("skip on fresh window");

endmodule

[tb/sv/testbench.sv]
module testbench;

  localparam int unsigned NOW_W        = frsl_pkg::NOW_W;
  localparam int unsigned RATE_W       = frsl_pkg::RATE_W;
  localparam int unsigned MISSED_W     = frsl_pkg::MISSED_W;
  localparam int unsigned MS_SCALE     = frsl_pkg::MS_SCALE;
  localparam int unsigned NOM_30       = frsl_pkg::NOM_30;
  localparam int unsigned NOM_1        = frsl_pkg::NOM_1;
  localparam int unsigned NOM_OTHER    = frsl_pkg::NOM_OTHER;
  localparam logic [RATE_W-1:0] RATE_CODE_30 = frsl_pkg::RATE_CODE_30;
  localparam logic [RATE_W-1:0] RATE_CODE_1  = frsl_pkg::RATE_CODE_1;
  localparam logic [RATE_W-1:0] RATE_RESET   = frsl_pkg::RATE_RESET;

  // Window depth matches the default parameter of the instance below.
  localparam int unsigned WIN_FRAMES_MAX = frsl_pkg::MAX_WINDOW_FRAMES_DEF;

  // Longest elapsed time (ms) a window may span at each nominal rate.
  localparam longint unsigned SPAN_30    = 64'(WIN_FRAMES_MAX) * MS_SCALE / NOM_30;
  localparam longint unsigned SPAN_1     = 64'(WIN_FRAMES_MAX) * MS_SCALE / NOM_1;
  localparam longint unsigned SPAN_OTHER = 64'(WIN_FRAMES_MAX) * MS_SCALE / NOM_OTHER;

  localparam int unsigned STALL_LIMIT  = 2000; // cycles with no transfer at all
  localparam int unsigned HOLD_CYCLES  = 200;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 8;    // tail after the last result
  localparam int unsigned FILL_FRAMES  = 60;   // frames stacked at the span edge

  typedef struct packed {
    logic                skip;
    logic [MISSED_W-1:0] missed;
  } frame_verdict_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  frsl_cfg_if cfg_bus();
  frsl_in_if  in_bus();
  frsl_out_if out_bus();

  frame_rate_skip_limiter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_bus),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // Shadow of the block's window state, updated at each input transfer.
  logic [RATE_W-1:0]   rate_set;    // frame_rate as last written
  logic [RATE_W-1:0]   win_rate;    // rate seen when the window opened
  logic [NOW_W-1:0]    win_start;
  logic [31:0]         win_frames;
  logic [MISSED_W-1:0] win_missed;

  frame_verdict_t verdict_q[$];     // decisions still owed by the block

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors        = 0;
  int unsigned stall_cycles  = 0;
  logic        in_offer      = 1'b0; // tb copy of in_bus.valid
  logic        hold_req      = 1'b0;
  logic        hold_on       = 1'b0;
  logic [NOW_W-1:0] clock_ms = '0;   // running timestamp for random traffic

  // ---------------------------------------------------------------------------
  // Decision predictor: one call per accepted frame, in transfer order.
  // ---------------------------------------------------------------------------
  function automatic frame_verdict_t judge_frame(input logic [NOW_W-1:0] now);
    logic [63:0]    nominal;
    logic [63:0]    allowed;
    logic [NOW_W-1:0] elapsed;
    frame_verdict_t v;
    // a zero start time or a new rate setting opens a fresh window
    if (win_start == '0 || win_rate != rate_set) begin
      win_rate   = rate_set;
      win_start  = now;
      win_frames = '0;
      win_missed = '0;
    end
    case (rate_set)
      RATE_CODE_30: nominal = 64'(NOM_30);
      RATE_CODE_1:  nominal = 64'(NOM_1);
      default:      nominal = 64'(NOM_OTHER);
    endcase
    win_frames = win_frames + 32'd1;
    elapsed = now - win_start;      // 32-bit wrap on purpose
    if (elapsed == '0)
      elapsed = NOW_W'(1);
    // window full or too old: reopen at this frame, which is not counted
    if (win_frames > WIN_FRAMES_MAX ||
        64'(elapsed) > (64'(WIN_FRAMES_MAX) * MS_SCALE) / nominal) begin
      win_frames = '0;
      win_missed = '0;
      win_start  = now;
      elapsed    = NOW_W'(1);
    end
    allowed = (nominal * 64'(elapsed)) / MS_SCALE;
    v.skip  = 64'(win_frames) > allowed + 64'd1;
    if (v.skip) begin
      win_missed = win_missed + MISSED_W'(1);
      win_frames = win_frames - 32'd1;
    end
    v.missed = win_missed;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compares each output transfer with the oldest decision.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_verdict_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with no frame pending: skip %0b frames_missed %0d",
                 $time, out_bus.skip, out_bus.frames_missed);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_bus.skip !== want.skip) begin
          $display("%0t: skip: expected %0b, actual %0b",
                   $time, want.skip, out_bus.skip);
          errors++;
        end
        if (out_bus.frames_missed !== want.missed) begin
          $display("%0t: frames_missed: expected %0d, actual %0d",
                   $time, want.missed, out_bus.frames_missed);
          errors++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    out_bus.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    forever begin
      wait (hold_req);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on  = 1'b0;
      hold_req = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side helpers. All are entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic lower_offer();
    if (in_offer) begin
      in_bus.valid <= 1'b0;
      in_offer = 1'b0;
    end
  endtask

  // One frame transfer; valid stays up on return so back-to-back frames
  // are not split by a gap.
  task automatic send_frame(input logic [NOW_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      lower_offer();
      @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.now_ms <= now;
    in_offer = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    verdict_q.push_back(judge_frame(now));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    lower_offer();
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_rate(input logic [RATE_W-1:0] rate);
    wait_drained();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.frame_rate <= rate;
    do @(posedge clk); while (!cfg_bus.ready);
    rate_set = rate;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Mostly a steady frame clock with jitter and bursts; now and then a
  // jump of one to two million ms, a raw random stamp, or all ones or zero.
  function automatic logic [NOW_W-1:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)
      clock_ms = clock_ms + $urandom_range(50);
    else if (pick < 80)
      clock_ms = clock_ms + $urandom_range(10);
    else if (pick < 88)
      clock_ms = clock_ms;
    else if (pick < 93)
      clock_ms = clock_ms + $urandom_range(2000000, 1000000);
    else if (pick < 97)
      clock_ms = $urandom;
    else
      clock_ms = $urandom_range(1) ? '1 : '0;
    return clock_ms;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(4))
      0:       return RATE_CODE_30;
      1:       return RATE_CODE_1;
      2:       return '0;
      3:       return '1;
      default: return RATE_W'($urandom_range(255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Timestamp corner cases at the reset rate (29.97 fps).
  task automatic test_directed_stamps();
    send_frame(32'd0);      // opens at zero, so the next frame reopens
    send_frame(32'd0);
    send_frame(32'd1000);   // window opens at 1000
    send_frame(32'd1000);   // same stamp: ahead of allowance, dropped
    send_frame(32'd1000);
    send_frame(32'd1033);
    send_frame(32'd1100);   // allowance caught up
    send_frame(32'd500);    // backwards: wrapped elapsed is past the span
    send_frame(32'(500 + SPAN_30));   // exactly at the span
    send_frame(32'(501 + SPAN_30));   // one past: window reopens
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd5);      // small elapsed across the 32-bit wrap
    send_frame(32'd5);
    send_frame(32'h8000_0000);
    send_frame(32'h5555_5555);
    send_frame(32'hAAAA_AAAA);
  endtask

  // 1 fps with its long span, the register extremes, and a rewrite of the
  // same value that must leave the window alone.
  task automatic test_rate_extremes();
    write_rate(RATE_CODE_1);
    send_frame(32'd7000);
    send_frame(32'(7000 + SPAN_1));
    send_frame(32'(7001 + SPAN_1));
    write_rate('0);
    send_frame(32'd20);
    send_frame(32'd20);
    write_rate('1);
    send_frame(32'd40);
    write_rate('1);
    send_frame(32'd1700);
    write_rate(RATE_CODE_30);
  endtask

  task automatic test_random_traffic(input int unsigned frames);
    repeat (frames) begin
      if ($urandom_range(99) == 0)
        write_rate(pick_rate());
      send_frame(next_stamp());
    end
  endtask

  // Receiver holds off long enough for the block to back up into its input;
  // then the sender waits for every result before going on.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_req = 1'b1;
    repeat (24) send_frame(next_stamp());
    wait_drained();
    repeat (24) send_frame(next_stamp());
  endtask

  // Stack frames on one 25 fps window at its span edge, where the allowance
  // is at its largest, so none is dropped.
  task automatic test_window_fill();
    set_idling(0, 0);
    write_rate(rate_set == 8'd7 ? 8'd9 : 8'd7);
    send_frame(32'd5000);
    repeat (FILL_FRAMES) send_frame(32'(5000 + SPAN_OTHER));
    send_frame(32'(5000 + SPAN_OTHER));
  endtask

  initial begin
    cfg_bus.valid      = 1'b0;
    cfg_bus.frame_rate = RATE_RESET;
    in_bus.valid       = 1'b0;
    in_bus.now_ms      = '0;
    out_bus.ready      = 1'b0;
    rate_set           = RATE_RESET;
    win_rate           = '0;
    win_start          = '0;
    win_frames         = '0;
    win_missed         = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_stamps();
    test_rate_extremes();
    set_idling(19, 80);
    test_random_traffic(230);
    set_idling(80, 19);
    test_random_traffic(230);
    set_idling(0, 0);
    test_random_traffic(230);
    test_backpressure();
    test_window_fill();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);  // catch any stray result
    if (errors == 0 && verdict_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
